[design/bmphdr_pkg.sv]
// Shared types and constants for the BMP header check and pixel marking block.
package bmphdr_pkg;

   // Verdict codes reported with the last word of a file.
   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_NOT_BMP    = 3'd1,
      STAT_BAD_DEPTH  = 3'd2,
      STAT_COMPRESSED = 3'd3,
      STAT_BAD_DIMS   = 3'd4,
      STAT_RANGE      = 3'd5
   } status_type;

   // Header layout: length and the byte positions of the captured fields.
   localparam int HDR_LEN       = 54;
   localparam int IDX_MAGIC_B   = 0;
   localparam int IDX_MAGIC_M   = 1;
   localparam int IDX_OFS_FIRST = 10;
   localparam int IDX_OFS_LAST  = 13;
   localparam int IDX_WID_FIRST = 18;
   localparam int IDX_WID_LAST  = 21;
   localparam int IDX_HGT_FIRST = 22;
   localparam int IDX_HGT_LAST  = 25;
   localparam int IDX_DEP_FIRST = 28;
   localparam int IDX_DEP_LAST  = 29;
   localparam int IDX_CMP_FIRST = 30;
   localparam int IDX_CMP_LAST  = 33;

   // Derivation schedule, run on header words once width, height and depth are complete.
   localparam int IDX_ROW_CALC  = 30;
   localparam int IDX_MUL_FIRST = 31;
   localparam int IDX_MUL_LAST  = 34;
   localparam int IDX_HDR_CODE  = 34;
   localparam int IDX_END_CALC  = 35;

   // Magic characters and accepted pixel depths.
   localparam logic [7:0]  MAGIC_B  = 8'h42;
   localparam logic [7:0]  MAGIC_M  = 8'h4D;
   localparam logic [15:0] DEPTH_24 = 16'd24;
   localparam logic [15:0] DEPTH_32 = 16'd32;
   localparam logic [2:0]  BPP_24   = 3'd3;
   localparam logic [2:0]  BPP_32   = 3'd4;

endpackage

[design/bmp_header_check_and_pad_mark.sv]
// Top level of the BMP header check and pixel/padding marker.
//
// The request channel carries a file one byte per word (req_data_byte), with
// req_last_byte set on the final word. Each accepted word yields exactly one
// response word in the cycle after acceptance, in the same order. The response
// flags whether the byte lies in pixel data and whether it is row data or
// row padding. The response for the last byte carries the verdict, width,
// absolute height and bytes per pixel; after it the block starts a new file.
// One word is accepted on every clock edge while the response register is
// free or being drained. The row length, stride and pixel length are built
// over header bytes 30 to 35 (one 35x8 partial product per byte from 31 to
// 34), so they are ready long before the pixel region opens.
// A response that is stalled stays in the output register and holds the
// request side off only while it is not taken (req_stall = valid and stall).
// Synchronous reset empties the output register and starts a new file.
// The byte counter is FILE_LEN_BITS wide and saturates at its maximum.
module bmp_header_check_and_pad_mark #(
   parameter int FILE_LEN_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_in_pixels,
   output logic                   rsp_row_data,
   output logic                   rsp_done_res,
   output bmphdr_pkg::status_type rsp_status,
   output logic [30:0]            rsp_width,
   output logic [31:0]            rsp_height,
   output logic [2:0]             rsp_bytes_per_pixel
);
   import bmphdr_pkg::*;

   localparam logic [FILE_LEN_BITS-1:0] IDX_MAX = '1;

   // Per-file state.
   logic [FILE_LEN_BITS-1:0] byte_index_ff, byte_index_in;
   logic                     magic_ok_ff, magic_ok_in;
   logic [34:0]              column_count_ff, column_count_in;
   logic [31:0]              pixel_offset_ff, pixel_offset_in;
   logic [31:0]              raw_width_ff, raw_width_in;
   logic [31:0]              raw_height_ff, raw_height_in;
   logic [15:0]              bit_depth_ff, bit_depth_in;
   logic [31:0]              compression_ff, compression_in;
   logic [31:0]              abs_height_ff, abs_height_in;
   logic [33:0]              row_length_ff, row_length_in;
   logic [34:0]              row_stride_ff, row_stride_in;
   logic [63:0]              pixel_length_ff, pixel_length_in;
   logic [64:0]              pixel_end_ff, pixel_end_in;
   status_type               hdr_code_ff, hdr_code_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        in_pixels_ff, in_pixels_in;
   logic        row_data_ff, row_data_in;
   logic        done_res_ff, done_res_in;
   status_type  status_ff, status_in;
   logic [30:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [2:0]  bpp_ff, bpp_in;

   // Helpers.
   logic                   accept;
   logic [1:0]             field_lane;
   logic [1:0]             mul_lane;
   logic                   depth_is_32;
   logic [34:0]            stride_round;
   logic [7:0]             height_byte;
   logic [42:0]            part_prod;
   logic [63:0]            part_shift;
   logic                   width_pos;
   status_type             hdr_code_now;
   logic [FILE_LEN_BITS:0] file_len;
   logic                   pix_hit;

   // Handshake: a new word enters whenever the response register can move.
   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;

   // All 32-bit fields start at an index that is 2 modulo 4.
   assign field_lane   = byte_index_ff[1:0] + 2'd2;
   assign mul_lane     = byte_index_ff[1:0] + 2'd1;
   assign depth_is_32  = (bit_depth_ff == DEPTH_32);
   assign width_pos    = (raw_width_ff != 32'd0) && !raw_width_ff[31];

   // One 35x8 partial product of stride times absolute height per header byte.
   // For a width that passes the checks, stride stays below 2^33 and height is at
   // most 2^31, so the product then fits in 64 bits and never counts as an overflow.
   assign height_byte  = abs_height_ff[{mul_lane, 3'b000} +: 8];
   assign part_prod    = 43'(row_stride_ff) * 43'(height_byte);
   assign part_shift   = 64'(part_prod) << {mul_lane, 3'b000};
   assign stride_round = {1'b0, row_length_in} + 35'd3;

   // Header checks one to four, in order of precedence.
   always_comb begin
      if (!magic_ok_ff) begin
         hdr_code_now = STAT_NOT_BMP;
      end else if (bit_depth_ff != DEPTH_24 && bit_depth_ff != DEPTH_32) begin
         hdr_code_now = STAT_BAD_DEPTH;
      end else if (compression_ff != 32'd0) begin
         hdr_code_now = STAT_COMPRESSED;
      end else if (!width_pos || raw_height_ff == 32'd0) begin
         hdr_code_now = STAT_BAD_DIMS;
      end else begin
         hdr_code_now = STAT_OK;
      end
   end

   // Capture of header fields and the derivation steps.
   always_comb begin
      magic_ok_in     = magic_ok_ff;
      pixel_offset_in = pixel_offset_ff;
      raw_width_in    = raw_width_ff;
      raw_height_in   = raw_height_ff;
      bit_depth_in    = bit_depth_ff;
      compression_in  = compression_ff;
      abs_height_in   = abs_height_ff;
      row_length_in   = row_length_ff;
      row_stride_in   = row_stride_ff;
      pixel_length_in = pixel_length_ff;
      pixel_end_in    = pixel_end_ff;
      hdr_code_in     = hdr_code_ff;

      if (byte_index_ff == FILE_LEN_BITS'(IDX_MAGIC_B) && req_data_byte != MAGIC_B) begin
         magic_ok_in = 1'b0;
      end
      if (byte_index_ff == FILE_LEN_BITS'(IDX_MAGIC_M) && req_data_byte != MAGIC_M) begin
         magic_ok_in = 1'b0;
      end
      if (byte_index_ff inside {[IDX_OFS_FIRST:IDX_OFS_LAST]}) begin
         pixel_offset_in[{field_lane, 3'b000} +: 8] = req_data_byte;
      end
      if (byte_index_ff inside {[IDX_WID_FIRST:IDX_WID_LAST]}) begin
         raw_width_in[{field_lane, 3'b000} +: 8] = req_data_byte;
      end
      if (byte_index_ff inside {[IDX_HGT_FIRST:IDX_HGT_LAST]}) begin
         raw_height_in[{field_lane, 3'b000} +: 8] = req_data_byte;
      end
      if (byte_index_ff inside {[IDX_DEP_FIRST:IDX_DEP_LAST]}) begin
         bit_depth_in[{byte_index_ff[0], 3'b000} +: 8] = req_data_byte;
      end
      if (byte_index_ff inside {[IDX_CMP_FIRST:IDX_CMP_LAST]}) begin
         compression_in[{field_lane, 3'b000} +: 8] = req_data_byte;
      end

      // Width, height and depth are complete here: row length and stride.
      if (byte_index_ff == FILE_LEN_BITS'(IDX_ROW_CALC)) begin
         abs_height_in   = raw_height_ff[31] ? (~raw_height_ff + 32'd1) : raw_height_ff;
         row_length_in   = depth_is_32 ? {raw_width_ff, 2'b00}
                                       : ({1'b0, raw_width_ff, 1'b0} + {2'b00, raw_width_ff});
         row_stride_in   = {stride_round[34:2], 2'b00};
         pixel_length_in = 64'd0;
      end
      if (byte_index_ff inside {[IDX_MUL_FIRST:IDX_MUL_LAST]}) begin
         pixel_length_in = pixel_length_ff + part_shift;
      end
      if (byte_index_ff == FILE_LEN_BITS'(IDX_HDR_CODE)) begin
         hdr_code_in = hdr_code_now;
      end
      if (byte_index_ff == FILE_LEN_BITS'(IDX_END_CALC)) begin
         pixel_end_in = 65'(pixel_offset_ff) + 65'(pixel_length_ff);
      end

      // The magic check starts over with the next file.
      if (req_last_byte) begin
         magic_ok_in = 1'b1;
      end
   end

   // Pixel region and row position of the current byte.
   assign pix_hit = (byte_index_ff >= FILE_LEN_BITS'(HDR_LEN)) && (hdr_code_ff == STAT_OK)
                    && (pixel_offset_ff >= 32'(HDR_LEN))
                    && (65'(byte_index_ff) >= 65'(pixel_offset_ff))
                    && (65'(byte_index_ff) < pixel_end_ff);

   assign file_len = {1'b0, byte_index_ff} + {{FILE_LEN_BITS{1'b0}}, 1'b1};

   // Response contents, counter advance and end-of-file verdict.
   always_comb begin
      in_pixels_in    = pix_hit;
      row_data_in     = 1'b0;
      column_count_in = column_count_ff;
      done_res_in     = req_last_byte;
      status_in       = STAT_OK;
      width_in        = 31'd0;
      height_in       = 32'd0;
      bpp_in          = 3'd0;
      byte_index_in   = (byte_index_ff != IDX_MAX) ? byte_index_ff + 1'b1 : byte_index_ff;

      if (pix_hit) begin
         row_data_in     = (34'(column_count_ff) < row_length_ff) && !column_count_ff[34];
         column_count_in = column_count_ff + 35'd1;
         if (column_count_in >= row_stride_ff) begin
            column_count_in = 35'd0;
         end
      end

      if (req_last_byte) begin
         if (file_len < (FILE_LEN_BITS+1)'(HDR_LEN)) begin
            status_in = STAT_NOT_BMP;
         end else begin
            status_in = hdr_code_ff;
         end
         if (status_in == STAT_OK && (pixel_offset_ff < 32'(HDR_LEN)
                                      || pixel_end_ff > 65'(file_len))) begin
            status_in = STAT_RANGE;
         end
         if (status_in == STAT_OK) begin
            width_in  = raw_width_ff[30:0];
            height_in = abs_height_ff;
            bpp_in    = depth_is_32 ? BPP_32 : BPP_24;
         end
         byte_index_in   = '0;
         column_count_in = 35'd0;
      end
   end

   // Output register empties when taken and refills on every accepted word.
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         byte_index_ff   <= '0;
         column_count_ff <= 35'd0;
         magic_ok_ff     <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            byte_index_ff   <= byte_index_in;
            column_count_ff <= column_count_in;
            magic_ok_ff     <= magic_ok_in;
         end
      end
   end

   // Header fields, derived lengths and response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_offset_ff <= pixel_offset_in;
         raw_width_ff    <= raw_width_in;
         raw_height_ff   <= raw_height_in;
         bit_depth_ff    <= bit_depth_in;
         compression_ff  <= compression_in;
         abs_height_ff   <= abs_height_in;
         row_length_ff   <= row_length_in;
         row_stride_ff   <= row_stride_in;
         pixel_length_ff <= pixel_length_in;
         pixel_end_ff    <= pixel_end_in;
         hdr_code_ff     <= hdr_code_in;
         in_pixels_ff    <= in_pixels_in;
         row_data_ff     <= row_data_in;
         done_res_ff     <= done_res_in;
         status_ff       <= status_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         bpp_ff          <= bpp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_in_pixels       = in_pixels_ff;
   assign rsp_row_data        = row_data_ff;
   assign rsp_done_res        = done_res_ff;
   assign rsp_status          = status_ff;
   assign rsp_width           = width_ff;
   assign rsp_height          = height_ff;
   assign rsp_bytes_per_pixel = bpp_ff;

   // Row data is only ever flagged inside the pixel region.
   a_row_in_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!row_data_ff || in_pixels_ff))
      else $error("row data flagged outside the pixel region");

   // Verdict fields stay clear on every word but the last.
   a_verdict_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !done_res_ff) |-> (status_ff == STAT_OK && bpp_ff == 3'd0
                                           && width_ff == 31'd0 && height_ff == 32'd0))
      else $error("verdict fields set on a word that is not the last");

   // A last word restarts the file counters.
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=> (byte_index_ff == '0 && column_count_ff == 35'd0))
      else $error("file counters not restarted after the last word");

   // Inside the pixel region the column counter stays below the stride.
   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      (byte_index_ff > FILE_LEN_BITS'(HDR_LEN) && hdr_code_ff == STAT_OK)
      |-> (column_count_ff < row_stride_ff))
      else $error("column counter ran past the row stride");

endmodule

[verif/bmp_header_check_and_pad_mark_tb.sv]
// Self-checking testbench for the BMP header check and pixel/padding marker.
`timescale 1ns / 1ps

module bmp_header_check_and_pad_mark_tb;
   import bmphdr_pkg::*;

   localparam int              WATCHDOG_LIMIT = 1000;
   localparam int              BYTE_TARGET    = 1550;
   localparam int              IDLE_PCT       = 7;
   localparam int              DRAIN_CYCLES   = 10;
   localparam int              REPORT_LIMIT   = 10;
   localparam longint unsigned POS_MAX        = 64'hFFFF_FFFF;

   // One response word as the block presents it.
   typedef struct {
      logic       in_pixels;
      logic       row_data;
      logic       done_res;
      status_type status;
      logic [30:0] width;
      logic [31:0] height;
      logic [2:0]  bpp;
   } mark_word_type;

   // Tracks the file being parsed and predicts the response for every byte.
   class bmp_mark_scoreboard;
      longint unsigned pos;
      logic [31:0]     ofs_val, wid_val, hgt_val, comp_val;
      logic [15:0]     depth_val;
      bit              magic_good;
      longint unsigned row_bytes, row_pitch, image_bytes, col_pos;
      bit              image_too_big;
      mark_word_type   pending_q[$];
      int              errors;

      function new();
         errors = 0;
         restart();
      endfunction

      // A new file starts after reset and after every last byte.
      function void restart();
         pos           = 0;
         ofs_val       = 0;
         wid_val       = 0;
         hgt_val       = 0;
         comp_val      = 0;
         depth_val     = 0;
         magic_good    = 1;
         row_bytes     = 0;
         row_pitch     = 0;
         image_bytes   = 0;
         col_pos       = 0;
         image_too_big = 0;
      endfunction

      // Height magnitude; the most negative height maps to 2^31.
      function longint unsigned rows_abs();
         if (hgt_val[31]) begin
            return {32'd0, ~hgt_val + 32'd1};
         end
         return {32'd0, hgt_val};
      endfunction

      function bit wide_ok();
         return (wid_val != 0) && !wid_val[31];
      endfunction

      function longint unsigned pixel_size();
         return (depth_val == DEPTH_32) ? 4 : 3;
      endfunction

      // Verdict from the header fields alone, in order of precedence.
      function status_type header_verdict();
         if (!magic_good) return STAT_NOT_BMP;
         if (depth_val != DEPTH_24 && depth_val != DEPTH_32) return STAT_BAD_DEPTH;
         if (comp_val != 0) return STAT_COMPRESSED;
         if (!wide_ok() || hgt_val == 0 || image_too_big) return STAT_BAD_DIMS;
         return STAT_OK;
      endfunction

      // Row length, padded stride and pixel region size once the header is in.
      function void size_image();
         longint unsigned rows;
         rows          = rows_abs();
         row_bytes     = {32'd0, wid_val} * pixel_size();
         row_pitch     = (row_bytes + 3) & ~64'd3;
         image_too_big = 0;
         image_bytes   = 0;
         if (!wide_ok() || rows == 0 || row_pitch == 0) return;
         if (rows > 64'hFFFF_FFFF_FFFF_FFFF / row_pitch) image_too_big = 1;
         else image_bytes = row_pitch * rows;
      endfunction

      // Little-endian header fields are collected byte by byte.
      function void capture(longint unsigned i, logic [7:0] b);
         if (i == IDX_MAGIC_B && b != MAGIC_B) magic_good = 0;
         if (i == IDX_MAGIC_M && b != MAGIC_M) magic_good = 0;
         if (i >= IDX_OFS_FIRST && i <= IDX_OFS_LAST) ofs_val[8*(i-IDX_OFS_FIRST) +: 8] = b;
         if (i >= IDX_WID_FIRST && i <= IDX_WID_LAST) wid_val[8*(i-IDX_WID_FIRST) +: 8] = b;
         if (i >= IDX_HGT_FIRST && i <= IDX_HGT_LAST) hgt_val[8*(i-IDX_HGT_FIRST) +: 8] = b;
         if (i >= IDX_DEP_FIRST && i <= IDX_DEP_LAST) depth_val[8*(i-IDX_DEP_FIRST) +: 8] = b;
         if (i >= IDX_CMP_FIRST && i <= IDX_CMP_LAST) comp_val[8*(i-IDX_CMP_FIRST) +: 8] = b;
         if (i == HDR_LEN - 1) size_image();
      endfunction

      // Called for every accepted request word.
      function void note_byte(logic [7:0] b, logic last);
         mark_word_type   w;
         longint unsigned i, flen, rows;
         w.in_pixels = 0;
         w.row_data  = 0;
         w.done_res  = 0;
         w.status    = STAT_OK;
         w.width     = 0;
         w.height    = 0;
         w.bpp       = 0;
         i = pos;
         if (i < HDR_LEN) capture(i, b);

         // Pixel region marking, with the column counter wrapping at the stride.
         if (i >= HDR_LEN && header_verdict() == STAT_OK && ofs_val >= HDR_LEN &&
             i >= ofs_val && (i - ofs_val) < image_bytes) begin
            w.in_pixels = 1;
            w.row_data  = (col_pos < row_bytes);
            col_pos++;
            if (col_pos >= row_pitch) col_pos = 0;
         end

         if (i < POS_MAX) pos = i + 1;

         // Verdict on the last byte of the file.
         if (last) begin
            flen       = i + 1;
            w.done_res = 1;
            if (flen < HDR_LEN) w.status = STAT_NOT_BMP;
            else w.status = header_verdict();
            if (w.status == STAT_OK && (ofs_val < HDR_LEN || image_bytes > flen ||
                                        ofs_val > flen - image_bytes)) begin
               w.status = STAT_RANGE;
            end
            if (w.status == STAT_OK) begin
               rows     = rows_abs();
               w.width  = wid_val[30:0];
               w.height = rows[31:0];
               w.bpp    = (depth_val == DEPTH_32) ? BPP_32 : BPP_24;
            end
            restart();
         end
         pending_q.push_back(w);
      endfunction

      // Called for every accepted response word.
      function void check_word(mark_word_type got);
         mark_word_type want;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) $display("unexpected response word at %0t", $realtime);
            return;
         end
         want = pending_q.pop_front();
         if (got.in_pixels !== want.in_pixels || got.row_data !== want.row_data ||
             got.done_res !== want.done_res || got.status !== want.status ||
             got.width !== want.width || got.height !== want.height ||
             got.bpp !== want.bpp) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("mismatch at %0t: expected pix=%0d row=%0d done=%0d st=%0d w=%0d h=%0d bpp=%0d",
                        $realtime, want.in_pixels, want.row_data, want.done_res,
                        want.status, want.width, want.height, want.bpp);
               $display("                   actual pix=%0d row=%0d done=%0d st=%0d w=%0d h=%0d bpp=%0d",
                        got.in_pixels, got.row_data, got.done_res,
                        got.status, got.width, got.height, got.bpp);
            end
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_in_pixels;
   logic       rsp_row_data;
   logic       rsp_done_res;
   status_type rsp_status;
   logic [30:0] rsp_width;
   logic [31:0] rsp_height;
   logic [2:0]  rsp_bytes_per_pixel;

   bmp_mark_scoreboard sb = new();
   logic [7:0]         hdr_buf [HDR_LEN];
   int                 cyc = 0;
   int                 stuck = 0;
   int                 sent_bytes = 0;
   bit                 calm;

   bmp_header_check_and_pad_mark dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_in_pixels       (rsp_in_pixels),
      .rsp_row_data        (rsp_row_data),
      .rsp_done_res        (rsp_done_res),
      .rsp_status          (rsp_status),
      .rsp_width           (rsp_width),
      .rsp_height          (rsp_height),
      .rsp_bytes_per_pixel (rsp_bytes_per_pixel)
   );

   always #5 clock = ~clock;

   // No idling on either side inside this window of cycles.
   assign calm = (cyc >= 700) && (cyc < 1200);

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck <= 0;
      end else begin
         stuck <= stuck + 1;
         if (stuck == WATCHDOG_LIMIT) begin
            $display("bmp_header_check_and_pad_mark regression: fail");
            $finish;
         end
      end
   end

   // Response side: check the word taken at this edge, then pick the next stall.
   always @(posedge clock) begin : rsp_side
      mark_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.in_pixels = rsp_in_pixels;
         got.row_data  = rsp_row_data;
         got.done_res  = rsp_done_res;
         got.status    = rsp_status;
         got.width     = rsp_width;
         got.height    = rsp_height;
         got.bpp       = rsp_bytes_per_pixel;
         sb.check_word(got);
      end
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // Writes a little-endian field into the staged header.
   function automatic void put_word(int at, logic [31:0] v, int nbytes);
      for (int k = 0; k < nbytes; k++) hdr_buf[at + k] = v[8*k +: 8];
   endfunction

   // Stages a header with random filler around the checked fields.
   function automatic void build_header(logic [31:0] ofs, logic [31:0] wid,
                                        logic [31:0] hgt, logic [15:0] dep);
      for (int k = 0; k < HDR_LEN; k++) hdr_buf[k] = 8'($urandom);
      hdr_buf[IDX_MAGIC_B] = MAGIC_B;
      hdr_buf[IDX_MAGIC_M] = MAGIC_M;
      put_word(IDX_OFS_FIRST, ofs, 4);
      put_word(IDX_WID_FIRST, wid, 4);
      put_word(IDX_HGT_FIRST, hgt, 4);
      put_word(IDX_DEP_FIRST, {16'd0, dep}, 2);
      put_word(IDX_CMP_FIRST, 32'd0, 4);
   endfunction

   // Stages a valid image header and returns the matching file length plus slack.
   function automatic int unsigned plan_image(int unsigned wid, int rows, bit deep,
                                              int unsigned ofs, int slack);
      int unsigned stride;
      int unsigned mag;
      stride = (wid * (deep ? 4 : 3) + 3) & ~32'd3;
      mag    = (rows < 0) ? -rows : rows;
      build_header(ofs, wid, rows, deep ? DEPTH_32 : DEPTH_24);
      return ofs + stride * mag + slack;
   endfunction

   // Sends one request word, with random idle cycles ahead of it.
   task automatic send_byte(logic [7:0] b, logic last);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid     <= 1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b, last);
      sent_bytes++;
   endtask

   // Sends the staged header followed by random body bytes.
   task automatic send_file(int unsigned flen);
      for (int unsigned k = 0; k < flen; k++) begin
         send_byte((k < HDR_LEN) ? hdr_buf[k] : 8'($urandom), k == flen - 1);
      end
   endtask

   initial begin : stimulus
      int unsigned flen;
      int          rows;
      int          pick;
      reset         = 1;
      req_valid     = 0;
      req_data_byte = 0;
      req_last_byte = 0;
      repeat (5) @(posedge clock);
      reset <= 0;

      // Well-formed images: padded single pixel, top-down 32-bit, multi-row 24-bit.
      send_file(plan_image(1, 1, 0, 54, 0));
      send_file(plan_image(3, -2, 1, 60, 3));
      send_file(plan_image(5, 3, 0, 54, 0));

      // Broken magic in either position.
      flen = plan_image(2, 1, 0, 54, 0);
      hdr_buf[IDX_MAGIC_B] = 8'h58;
      send_file(flen);
      flen = plan_image(2, 1, 0, 54, 0);
      hdr_buf[IDX_MAGIC_M] = 8'hFF;
      send_file(flen);

      // Unsupported depths, including the largest code.
      flen = plan_image(2, 1, 0, 54, 0);
      put_word(IDX_DEP_FIRST, 32'd16, 2);
      send_file(flen);
      flen = plan_image(2, 1, 0, 54, 0);
      put_word(IDX_DEP_FIRST, 32'hFFFF, 2);
      send_file(flen);

      // Compressed image with the largest code.
      flen = plan_image(2, 1, 1, 54, 0);
      put_word(IDX_CMP_FIRST, 32'hFFFF_FFFF, 4);
      send_file(flen);

      // Bad dimensions: zero width, negative width, zero height.
      flen = plan_image(2, 1, 0, 54, 0);
      put_word(IDX_WID_FIRST, 32'd0, 4);
      send_file(flen);
      flen = plan_image(2, 1, 0, 54, 0);
      put_word(IDX_WID_FIRST, 32'h8000_0000, 4);
      send_file(flen);
      flen = plan_image(2, 1, 0, 54, 0);
      put_word(IDX_HGT_FIRST, 32'd0, 4);
      send_file(flen);

      // Pixel offset inside the header, and the largest offset.
      flen = plan_image(2, 1, 0, 54, 4);
      put_word(IDX_OFS_FIRST, 32'd53, 4);
      send_file(flen);
      flen = plan_image(2, 1, 0, 54, 4);
      put_word(IDX_OFS_FIRST, 32'hFFFF_FFFF, 4);
      send_file(flen);

      // Widest row and tallest image: file ends inside the pixel region.
      flen = plan_image(1, 1, 1, 54, 0);
      put_word(IDX_WID_FIRST, 32'h7FFF_FFFF, 4);
      send_file(70);
      flen = plan_image(1, 1, 0, 54, 0);
      put_word(IDX_HGT_FIRST, 32'h8000_0000, 4);
      send_file(64);

      // Files too short for a header: one byte, and one byte short.
      flen = plan_image(1, 1, 0, 54, 0);
      send_file(1);
      flen = plan_image(1, 1, 0, 54, 0);
      send_file(HDR_LEN - 1);

      // Pixel data cut short by two bytes.
      send_file(plan_image(2, 2, 0, 54, 0) - 2);

      // Random files: mostly well-formed, some with one field broken or cut short, some noise.
      while (sent_bytes < BYTE_TARGET) begin
         pick = $urandom_range(99);
         rows = $urandom_range(1, 4);
         if ($urandom_range(1)) rows = -rows;
         flen = plan_image(($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6),
                           rows, $urandom_range(1), $urandom_range(54, 64), $urandom_range(0, 4));
         if (pick >= 75 && pick < 92) begin
            case ($urandom_range(6))
               0: hdr_buf[$urandom_range(IDX_MAGIC_B, IDX_MAGIC_M)] = 8'($urandom);
               1: put_word(IDX_DEP_FIRST, $urandom_range(0, 65535), 2);
               2: put_word(IDX_CMP_FIRST, $urandom_range(1, 3), 4);
               3: put_word(IDX_WID_FIRST, $urandom_range(1) ? 32'd0 : ($urandom | 32'h8000_0000), 4);
               4: put_word(IDX_HGT_FIRST, 32'd0, 4);
               5: put_word(IDX_OFS_FIRST, $urandom_range(0, HDR_LEN - 1), 4);
               default: flen = flen - $urandom_range(1, 8);
            endcase
         end else if (pick >= 92) begin
            for (int k = 0; k < HDR_LEN; k++) hdr_buf[k] = 8'($urandom);
            flen = $urandom_range(1, 120);
         end
         send_file(flen);
      end
      req_valid <= 0;

      // Drain outstanding responses, then idle before reporting the result.
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("bmp_header_check_and_pad_mark regression: pass");
      end else begin
         $display("bmp_header_check_and_pad_mark regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
design/bmphdr_pkg.sv
design/bmp_header_check_and_pad_mark.sv
verif/bmp_header_check_and_pad_mark_tb.sv
